// File: src/rtbp_pkg.sv
// Shared types, constants and helper functions for the RGBA bit-field pixel packer.
`default_nettype none

package rtbp_pkg;

	// Byte order of the emitted pixel: 0 sends the low byte first, 1 the high byte first.
	localparam bit BIG_ENDIAN_ORDER = 1'b0;

	// Queue depth between the front and the back; must be a power of two.
	localparam int RTBP_QDEPTH = 2;
	localparam int RTBP_QPTR_W = $clog2(RTBP_QDEPTH);
	localparam int RTBP_QLVL_W = $clog2(RTBP_QDEPTH + 1);

	// Configuration register indexes.
	localparam logic [2:0] REG_RED_OFFSET      = 3'd0;
	localparam logic [2:0] REG_GREEN_OFFSET    = 3'd1;
	localparam logic [2:0] REG_BLUE_OFFSET     = 3'd2;
	localparam logic [2:0] REG_ALPHA_OFFSET    = 3'd3;
	localparam logic [2:0] REG_CHANNEL_LENGTHS = 3'd4;
	localparam logic [2:0] REG_PIXEL_BITS      = 3'd5;

	// Configuration as seen by the front.
	typedef struct packed {
		logic [4:0]  red_offset;
		logic [4:0]  green_offset;
		logic [4:0]  blue_offset;
		logic [4:0]  alpha_offset;
		logic [15:0] channel_lengths;
		logic [5:0]  pixel_bits;
	} rtbp_cfg_t;

	// One queued pixel: the packed word and the index of its final byte.
	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  last_idx;
	} rtbp_entry_t;

	// Keep the top len bits of one channel byte and move them to bit offset off.
	function automatic logic [31:0] place_channel(input logic [7:0] chan,
			input logic [3:0] len, input logic [4:0] off);
		logic [3:0]  n;
		logic [7:0]  b;
		logic [31:0] w;
		n = (len > 4'd8) ? 4'd8 : len;
		b = (n == 4'd0) ? 8'd0 : (chan >> (4'd8 - n));
		w = {24'd0, b} << off;
		return w;
	endfunction

	// Index of the final byte: one more for each of the thresholds 8, 16 and 24 exceeded.
	function automatic logic [1:0] last_byte_idx(input logic [5:0] bpp);
		logic [1:0] c;
		c = 2'd0;
		if (bpp > 6'd8)  c = c + 2'd1;
		if (bpp > 6'd16) c = c + 2'd1;
		if (bpp > 6'd24) c = c + 2'd1;
		return c;
	endfunction

endpackage

`default_nettype wire

// File: src/rtbp_front.sv
// Front stage: accepts source pixels, packs the channel fields and queues the result.
`default_nettype none

module rtbp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rtbp_pkg::rtbp_cfg_t  cfg,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [31:0]          s_axis_tdata,
	input  wire logic                 q_full,
	output logic                      q_push,
	output rtbp_pkg::rtbp_entry_t     q_data
);
	import rtbp_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [1:0]  last_s1;
	logic [31:0] packed_word;
	logic        take;

	// Combine the four placed channel fields.
	always_comb begin
		packed_word = place_channel(s_axis_tdata[7:0],   cfg.channel_lengths[3:0],
				cfg.red_offset)
			| place_channel(s_axis_tdata[15:8],  cfg.channel_lengths[7:4],
				cfg.green_offset)
			| place_channel(s_axis_tdata[23:16], cfg.channel_lengths[11:8],
				cfg.blue_offset)
			| place_channel(s_axis_tdata[31:24], cfg.channel_lengths[15:12],
				cfg.alpha_offset);
	end

	// The stage takes a new request whenever it is empty or draining into the queue.
	assign q_push        = valid_s1 && !q_full;
	assign s_axis_tready = !valid_s1 || !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign q_data        = '{word: word_s1, last_idx: last_s1};

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= packed_word;
			last_s1 <= last_byte_idx(cfg.pixel_bits);
		end
	end

endmodule

`default_nettype wire

// File: src/rtbp_queue.sv
// Small first-in first-out queue of packed pixels between the front and the back.
`default_nettype none

module rtbp_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire rtbp_pkg::rtbp_entry_t push_data,
	output logic                       full,
	input  wire logic                  pop,
	output rtbp_pkg::rtbp_entry_t      head,
	output logic                       empty
);
	import rtbp_pkg::*;

	rtbp_entry_t              mem_q [RTBP_QDEPTH];
	logic [RTBP_QPTR_W-1:0]   wr_ptr_q;
	logic [RTBP_QPTR_W-1:0]   rd_ptr_q;
	logic [RTBP_QLVL_W-1:0]   level_q;

	assign full  = (level_q == RTBP_QLVL_W'(RTBP_QDEPTH));
	assign empty = (level_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// The front never pushes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");

	// The back never pops an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");

	// The level never exceeds the depth.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= RTBP_QLVL_W'(RTBP_QDEPTH)) else $error("queue level out of range");

endmodule

`default_nettype wire

// File: src/rtbp_back.sv
// Back stage: splits each queued word into bytes and drives the output register.
`default_nettype none

module rtbp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rtbp_pkg::rtbp_entry_t head,
	input  wire logic                  q_empty,
	output logic                       q_pop,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [7:0]                 m_axis_tdata,
	output logic                       m_axis_tlast
);
	import rtbp_pkg::*;

	logic [1:0] k_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       is_last;
	logic [1:0] byte_idx;

	// The output register refills when a pixel is queued and the register is empty or being taken.
	assign load     = !q_empty && (!out_valid_q || m_axis_tready);
	assign is_last  = (k_q == head.last_idx);
	assign q_pop    = load && is_last;
	assign byte_idx = BIG_ENDIAN_ORDER ? (head.last_idx - k_q) : k_q;

	// Byte counter within the current pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 2'd0;
		end else if (load) begin
			k_q <= is_last ? 2'd0 : k_q + 2'd1;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.word[{byte_idx, 3'b000} +: 8];
			out_last_q <= is_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// The byte counter stays within the pixel at the head of the queue.
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> k_q <= head.last_idx) else $error("byte counter past last byte");

	// With nothing queued the counter sits at the first byte.
	a_k_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> k_q == 2'd0) else $error("byte counter not cleared");

	// Retiring a pixel presents its final byte next.
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (m_axis_tvalid && m_axis_tlast)) else $error("pop without last byte");

endmodule

`default_nettype wire

// File: src/rgba_to_bitfield_pixel_packer_top.sv
// Top level of the RGBA bit-field pixel packer: configuration registers and stage wiring.
//
// Usage: source pixels arrive on the s_axis channel, one 32-bit RGBA pixel per request
// (red in bits 7:0, alpha in bits 31:24). Each channel keeps the top bits given by its
// length and lands at its configured offset in a 32-bit word; the word leaves on the
// m_axis channel as 1 to 4 byte requests, with tlast on the final byte of the pixel.
// The configuration port writes register cfg_index from cfg_wdata when cfg_we is high;
// write only while the block holds no pixel.
// The first byte of a pixel passes the front register, the queue and the output register
// before it is valid on m_axis. Throughput: the byte serializer emits one byte per cycle
// while a pixel is queued and the receiver takes it; a pixel leaves as one to four bytes,
// four at 32 bits per pixel. The front accepts a pixel every cycle while the two-entry
// queue between front and back has room.
// Reset clears all valid flags and the queue and loads the default register values
// (offsets 0/8/16/24, lengths 8, 32 bits per pixel). When the receiver stalls the
// output byte holds, the queue fills and then s_axis_tready drops.
`default_nettype none

module rgba_to_bitfield_pixel_packer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	// Pixel input.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // pixel_in[31:0]
	// Byte output.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // out_byte[7:0]
	output logic             m_axis_tlast    // last_byte
);
	import rtbp_pkg::*;

	rtbp_cfg_t   cfg_q;
	rtbp_entry_t push_data;
	rtbp_entry_t head;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_offset      <= 5'd0;
			cfg_q.green_offset    <= 5'd8;
			cfg_q.blue_offset     <= 5'd16;
			cfg_q.alpha_offset    <= 5'd24;
			cfg_q.channel_lengths <= 16'h8888;
			cfg_q.pixel_bits      <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RED_OFFSET:      cfg_q.red_offset      <= cfg_wdata[4:0];
				REG_GREEN_OFFSET:    cfg_q.green_offset    <= cfg_wdata[4:0];
				REG_BLUE_OFFSET:     cfg_q.blue_offset     <= cfg_wdata[4:0];
				REG_ALPHA_OFFSET:    cfg_q.alpha_offset    <= cfg_wdata[4:0];
				REG_CHANNEL_LENGTHS: cfg_q.channel_lengths <= cfg_wdata;
				REG_PIXEL_BITS:      cfg_q.pixel_bits      <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	rtbp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	rtbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty)
	);

	rtbp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
